/* sv/dcbc_pkg.sv */
`timescale 1ns / 1ps

package dcbc_pkg;

    // Code space and the derived widths of the presence map
    localparam int CODE_SPACE = 4096;
    localparam int CODE_W     = 12;
    localparam int CUR_W      = CODE_W + 1;
    localparam int ROW_W      = 16;
    localparam int BIT_W      = $clog2(ROW_W);
    localparam int ROWS       = CODE_SPACE / ROW_W;
    localparam int ROW_IW     = $clog2(ROWS);
    localparam int WORD_W     = 16;
    localparam int FUNC_W     = 2;

    localparam logic [CODE_W-1:0] COUNT_MAX  = 12'hFFF;
    localparam logic [CUR_W-1:0]  CURSOR_INIT = 13'd1;

    // Function codes on the input port
    localparam logic [FUNC_W-1:0] FUNC_FEED  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_FETCH = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

    // Classified operation handed from front to back
    typedef enum logic [1:0] {
        OP_FEED,
        OP_FETCH,
        OP_CLEAR,
        OP_NOP
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [CODE_W-1:0] code;
    } cmd_t;

endpackage

/* sv/distinct_code_bitmap_collector_core.sv */
`timescale 1ns / 1ps

// Distinct code collector. Input words arrive on in_valid/in_ready with
// func (feed, fetch, clear) and word_value; one result word per input word
// leaves on out_valid/out_ready with the distinct count, a fetched code,
// its valid flag and a new-code flag.
// A front stage classifies each word and drops padding and out-of-range
// codes; a two-entry queue decouples it from the back end, which owns the
// presence map (256 rows of 16 bits in RAM plus a per-row nonempty flag).
// Clear and no-op are answered from the idle state; feed reads the row and,
// if the code is new, writes it back in S_FEED; fetch walks rows from the
// cursor, reading only nonempty ones (S_SCAN, then S_CHECK). Clear and
// no-op go one word a cycle while out_ready is high; a feed or fetch ends
// before the next word is taken. Clear drops all nonempty flags at once.
// Reset empties the map, zeroes the count and sets the fetch cursor to one.
// While the receiver stalls, the result is held in the output register and
// the front and queue keep taking up to three more words.

module distinct_code_bitmap_collector_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [dcbc_pkg::FUNC_W-1:0]  func,
    input  logic [dcbc_pkg::WORD_W-1:0]  word_value,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [dcbc_pkg::CODE_W-1:0]  distinct_count,
    output logic [dcbc_pkg::CODE_W-1:0]  found_code,
    output logic                         code_valid,
    output logic                         was_new
);

    logic           f_valid, f_ready;
    dcbc_pkg::cmd_t f_cmd;
    logic           q_valid, q_ready;
    dcbc_pkg::cmd_t q_cmd;

    dcbc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .func       (func),
        .word_value (word_value),
        .cmd_valid  (f_valid),
        .cmd_ready  (f_ready),
        .cmd        (f_cmd)
    );

    dcbc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_cmd   (f_cmd),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_cmd    (q_cmd)
    );

    dcbc_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_valid      (q_valid),
        .cmd_ready      (q_ready),
        .cmd            (q_cmd),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .distinct_count (distinct_count),
        .found_code     (found_code),
        .code_valid     (code_valid),
        .was_new        (was_new)
    );

endmodule

/* sv/dcbc_ram.sv */
`timescale 1ns / 1ps

module dcbc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Single write port, registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* sv/dcbc_front.sv */
`timescale 1ns / 1ps

module dcbc_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [dcbc_pkg::FUNC_W-1:0]  func,
    input  logic [dcbc_pkg::WORD_W-1:0]  word_value,
    output logic                         cmd_valid,
    input  logic                         cmd_ready,
    output dcbc_pkg::cmd_t               cmd
);

    logic           valid_reg, valid_next;
    dcbc_pkg::cmd_t cmd_reg, cmd_next;
    logic [14:0]    code15;
    logic           feed_ok;
    dcbc_pkg::cmd_t cls;

    // Bit 15 masked off; zero padding and out-of-range codes are dropped
    assign code15  = word_value[14:0];
    assign feed_ok = (code15 != 15'd0) &&
                     (17'({2'b00, code15}) < 17'(dcbc_pkg::CODE_SPACE));

    always_comb
    begin
        cls.code = code15[dcbc_pkg::CODE_W-1:0];
        case (func)
            dcbc_pkg::FUNC_FEED:  cls.op = feed_ok ? dcbc_pkg::OP_FEED : dcbc_pkg::OP_NOP;
            dcbc_pkg::FUNC_FETCH: cls.op = dcbc_pkg::OP_FETCH;
            dcbc_pkg::FUNC_CLEAR: cls.op = dcbc_pkg::OP_CLEAR;
            default:              cls.op = dcbc_pkg::OP_NOP;
        endcase
    end

    // One-word holding stage in front of the queue
    assign in_ready  = !valid_reg || cmd_ready;
    assign cmd_valid = valid_reg;
    assign cmd       = cmd_reg;

    always_comb
    begin
        valid_next = valid_reg && !cmd_ready;
        cmd_next   = cmd_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
            cmd_next   = cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

endmodule

/* sv/dcbc_queue.sv */
`timescale 1ns / 1ps

module dcbc_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  dcbc_pkg::cmd_t push_cmd,
    output logic           pop_valid,
    input  logic           pop_ready,
    output dcbc_pkg::cmd_t pop_cmd
);

    dcbc_pkg::cmd_t entry_reg [2];
    logic [1:0]     fill_reg, fill_next;
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic           do_push, do_pop;

    assign push_ready = (fill_reg != 2'd2);
    assign pop_valid  = (fill_reg != 2'd0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        fill_next   = fill_reg;
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (!do_push && do_pop)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg   <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            fill_reg   <= fill_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

/* sv/dcbc_back.sv */
`timescale 1ns / 1ps

module dcbc_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cmd_valid,
    output logic                         cmd_ready,
    input  dcbc_pkg::cmd_t               cmd,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [dcbc_pkg::CODE_W-1:0]  distinct_count,
    output logic [dcbc_pkg::CODE_W-1:0]  found_code,
    output logic                         code_valid,
    output logic                         was_new
);

    localparam int CODE_W = dcbc_pkg::CODE_W;
    localparam int CUR_W  = dcbc_pkg::CUR_W;
    localparam int ROW_W  = dcbc_pkg::ROW_W;
    localparam int BIT_W  = dcbc_pkg::BIT_W;
    localparam int ROWS   = dcbc_pkg::ROWS;
    localparam int ROW_IW = dcbc_pkg::ROW_IW;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FEED,
        S_SCAN,
        S_CHECK
    } state_t;

    state_t              state_reg, state_next;
    logic [ROW_IW-1:0]   row_reg, row_next;
    logic                first_reg, first_next;
    logic [CODE_W-1:0]   code_reg, code_next;
    logic [CUR_W-1:0]    cursor_reg, cursor_next;
    logic [CODE_W-1:0]   count_reg, count_next;
    logic [ROWS-1:0]     nonempty_reg, nonempty_next;
    logic                out_valid_reg, out_valid_next;
    logic [CODE_W-1:0]   found_reg, found_next;
    logic                cv_reg, cv_next;
    logic                new_reg, new_next;

    logic                slot_free;
    logic                pop;
    logic                ram_wr_en, ram_rd_en;
    logic [ROW_IW-1:0]   ram_wr_addr, ram_rd_addr;
    logic [ROW_W-1:0]    ram_wr_data, ram_rd_data;
    logic [ROW_W-1:0]    feed_row, scan_row, scan_mask;
    logic [BIT_W-1:0]    feed_bit, first_bit;
    logic                last_row;

    // Presence map: one row of bits per memory word
    dcbc_ram #(
        .WIDTH(ROW_W),
        .DEPTH(ROWS)
    ) u_map (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign slot_free = !out_valid_reg || out_ready;
    assign pop       = (state_reg == S_IDLE) && cmd_valid && slot_free;
    assign cmd_ready = pop;
    assign last_row  = (row_reg == ROW_IW'(ROWS - 1));

    // A row never written since the last clear reads as empty
    assign feed_row  = nonempty_reg[row_reg] ? ram_rd_data : '0;
    assign feed_bit  = code_reg[BIT_W-1:0];

    // Bits below the cursor are skipped in the first row of a walk
    always_comb
    begin
        for (int i = 0; i < ROW_W; i++)
        begin
            scan_mask[i] = !first_reg || (BIT_W'(i) >= cursor_reg[BIT_W-1:0]);
        end
        scan_row = ram_rd_data & scan_mask;
    end

    // Lowest set bit of the masked row
    always_comb
    begin
        first_bit = '0;
        for (int i = ROW_W - 1; i >= 0; i--)
        begin
            if (scan_row[i])
            begin
                first_bit = BIT_W'(i);
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        row_next       = row_reg;
        first_next     = first_reg;
        code_next      = code_reg;
        cursor_next    = cursor_reg;
        count_next     = count_reg;
        nonempty_next  = nonempty_reg;
        out_valid_next = out_valid_reg && !out_ready;
        found_next     = found_reg;
        cv_next        = cv_reg;
        new_next       = new_reg;
        ram_wr_en      = 1'b0;
        ram_wr_addr    = row_reg;
        ram_wr_data    = feed_row | (ROW_W'(1) << feed_bit);
        ram_rd_en      = 1'b0;
        ram_rd_addr    = row_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (pop)
                begin
                    case (cmd.op)
                        dcbc_pkg::OP_FEED:
                        begin
                            code_next   = cmd.code;
                            row_next    = cmd.code[CODE_W-1:BIT_W];
                            ram_rd_en   = 1'b1;
                            ram_rd_addr = cmd.code[CODE_W-1:BIT_W];
                            state_next  = S_FEED;
                        end
                        dcbc_pkg::OP_FETCH:
                        begin
                            if (cursor_reg >= CUR_W'(dcbc_pkg::CODE_SPACE))
                            begin
                                out_valid_next = 1'b1;
                                found_next     = '0;
                                cv_next        = 1'b0;
                                new_next       = 1'b0;
                            end
                            else
                            begin
                                row_next   = cursor_reg[CODE_W-1:BIT_W];
                                first_next = 1'b1;
                                state_next = S_SCAN;
                            end
                        end
                        dcbc_pkg::OP_CLEAR:
                        begin
                            nonempty_next  = '0;
                            count_next     = '0;
                            cursor_next    = dcbc_pkg::CURSOR_INIT;
                            out_valid_next = 1'b1;
                            found_next     = '0;
                            cv_next        = 1'b0;
                            new_next       = 1'b0;
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                            found_next     = '0;
                            cv_next        = 1'b0;
                            new_next       = 1'b0;
                        end
                    endcase
                end
            end

            // Read-modify-write of the code's row
            S_FEED:
            begin
                out_valid_next = 1'b1;
                found_next     = '0;
                cv_next        = 1'b0;
                new_next       = 1'b0;
                if (!feed_row[feed_bit])
                begin
                    ram_wr_en              = 1'b1;
                    nonempty_next[row_reg] = 1'b1;
                    new_next               = 1'b1;
                    if (count_reg != dcbc_pkg::COUNT_MAX)
                    begin
                        count_next = count_reg + CODE_W'(1);
                    end
                end
                state_next = S_IDLE;
            end

            // Empty rows are skipped without a memory read
            S_SCAN:
            begin
                if (nonempty_reg[row_reg])
                begin
                    ram_rd_en  = 1'b1;
                    state_next = S_CHECK;
                end
                else if (last_row)
                begin
                    cursor_next    = CUR_W'(dcbc_pkg::CODE_SPACE);
                    out_valid_next = 1'b1;
                    found_next     = '0;
                    cv_next        = 1'b0;
                    new_next       = 1'b0;
                    state_next     = S_IDLE;
                end
                else
                begin
                    row_next   = row_reg + ROW_IW'(1);
                    first_next = 1'b0;
                end
            end

            S_CHECK:
            begin
                if (scan_row != '0)
                begin
                    found_next     = {row_reg, first_bit};
                    cursor_next    = CUR_W'({row_reg, first_bit}) + CUR_W'(1);
                    out_valid_next = 1'b1;
                    cv_next        = 1'b1;
                    new_next       = 1'b0;
                    state_next     = S_IDLE;
                end
                else if (last_row)
                begin
                    cursor_next    = CUR_W'(dcbc_pkg::CODE_SPACE);
                    out_valid_next = 1'b1;
                    found_next     = '0;
                    cv_next        = 1'b0;
                    new_next       = 1'b0;
                    state_next     = S_IDLE;
                end
                else
                begin
                    row_next   = row_reg + ROW_IW'(1);
                    first_next = 1'b0;
                    state_next = S_SCAN;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State, map summary, count, cursor and the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            row_reg       <= '0;
            first_reg     <= 1'b0;
            code_reg      <= '0;
            cursor_reg    <= dcbc_pkg::CURSOR_INIT;
            count_reg     <= '0;
            nonempty_reg  <= '0;
            out_valid_reg <= 1'b0;
            found_reg     <= '0;
            cv_reg        <= 1'b0;
            new_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            first_reg     <= first_next;
            code_reg      <= code_next;
            cursor_reg    <= cursor_next;
            count_reg     <= count_next;
            nonempty_reg  <= nonempty_next;
            out_valid_reg <= out_valid_next;
            found_reg     <= found_next;
            cv_reg        <= cv_next;
            new_reg       <= new_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign distinct_count = count_reg;
    assign found_code     = found_reg;
    assign code_valid     = cv_reg;
    assign was_new        = new_reg;

endmodule

/* tb/dcbc_collector_checker.sv */
`timescale 1ns / 1ps

// Watches both channels of the collector, keeps its own copy of the presence
// map, count and fetch cursor, and compares every result word in order.
module dcbc_collector_checker
    import dcbc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  logic [FUNC_W-1:0] func,
    input  logic [WORD_W-1:0] word_value,
    input  logic              out_valid,
    input  logic              out_ready,
    input  logic [CODE_W-1:0] distinct_count,
    input  logic [CODE_W-1:0] found_code,
    input  logic              code_valid,
    input  logic              was_new,
    output int                fail_count,
    output int                pending,
    output int                results_seen,
    output int                fetch_hits,
    output int                fetch_misses,
    output int                new_codes,
    output int                peak_count
);

    typedef struct packed {
        logic [CODE_W-1:0] count;
        logic [CODE_W-1:0] code;
        logic              hit;
        logic              fresh;
    } result_t;

    // Model state
    logic [CODE_SPACE-1:0] seen_map;
    logic [CODE_W-1:0]     unique_count;
    logic [CUR_W-1:0]      fetch_cursor;
    result_t               expected_results[$];

    int n_fail;
    int n_seen;
    int n_hits;
    int n_misses;
    int n_new;
    int n_peak;

    // Apply one input word to the model and return the result it must produce
    function automatic result_t collect_word(input logic [FUNC_W-1:0] f,
                                             input logic [WORD_W-1:0] w);
        result_t           r;
        logic [WORD_W-2:0] code;
        logic [CUR_W-1:0]  c;
        r = '0;
        case (f)
            FUNC_FEED:
            begin
                // bit 15 is masked; padding and out-of-range codes are dropped
                code = w[WORD_W-2:0];
                if (code != '0 && code < CODE_SPACE && !seen_map[code[CODE_W-1:0]])
                begin
                    seen_map[code[CODE_W-1:0]] = 1'b1;
                    if (unique_count != COUNT_MAX)
                        unique_count = unique_count + 1'b1;
                    r.fresh = 1'b1;
                end
            end
            FUNC_FETCH:
            begin
                // walk up from the cursor; park at the top when nothing is left
                c = fetch_cursor;
                while (c < CODE_SPACE && !seen_map[c[CODE_W-1:0]])
                    c = c + 1'b1;
                if (c < CODE_SPACE)
                begin
                    r.code       = c[CODE_W-1:0];
                    r.hit        = 1'b1;
                    fetch_cursor = c + 1'b1;
                end
                else
                begin
                    fetch_cursor = CUR_W'(CODE_SPACE);
                end
            end
            FUNC_CLEAR:
            begin
                seen_map     = '0;
                unique_count = '0;
                fetch_cursor = CURSOR_INIT;
            end
            default: ;
        endcase
        r.count = unique_count;
        return r;
    endfunction

    task automatic flag_field(input string field, input logic [CODE_W-1:0] want,
                              input logic [CODE_W-1:0] got);
        $display("%0t ns: %s expected %0d, actual %0d", $time, field, want, got);
        n_fail++;
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (!rst_n)
        begin
            seen_map     = '0;
            unique_count = '0;
            fetch_cursor = CURSOR_INIT;
            expected_results.delete();
            n_fail   = 0;
            n_seen   = 0;
            n_hits   = 0;
            n_misses = 0;
            n_new    = 0;
            n_peak   = 0;
        end
        else
        begin
            // result side first: it can only belong to an earlier word
            if (out_valid && out_ready)
            begin
                n_seen++;
                if (expected_results.size() == 0)
                begin
                    $display("%0t ns: result word with none expected, count %0d code %0d",
                             $time, distinct_count, found_code);
                    n_fail++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (distinct_count !== want.count)
                        flag_field("distinct_count", want.count, distinct_count);
                    if (found_code !== want.code)
                        flag_field("found_code", want.code, found_code);
                    if (code_valid !== want.hit)
                        flag_field("code_valid", CODE_W'(want.hit), CODE_W'(code_valid));
                    if (was_new !== want.fresh)
                        flag_field("was_new", CODE_W'(want.fresh), CODE_W'(was_new));
                end
            end

            if (in_valid && in_ready)
            begin
                want = collect_word(func, word_value);
                expected_results.push_back(want);
                if (func == FUNC_FETCH)
                begin
                    if (want.hit)
                        n_hits++;
                    else
                        n_misses++;
                end
                if (want.fresh)
                    n_new++;
                if (int'(want.count) > n_peak)
                    n_peak = int'(want.count);
            end
        end

        fail_count   <= n_fail;
        pending      <= expected_results.size();
        results_seen <= n_seen;
        fetch_hits   <= n_hits;
        fetch_misses <= n_misses;
        new_codes    <= n_new;
        peak_count   <= n_peak;
    end

endmodule

/* tb/tb_distinct_code_bitmap_collector_core.sv */
`timescale 1ns / 1ps

module tb_distinct_code_bitmap_collector_core;
    import dcbc_pkg::*;

    localparam int CLK_PERIOD     = 4;
    localparam int RESET_CYCLES   = 7;
    localparam int TOTAL_WORDS    = 1300;
    localparam int QUIET_WORDS    = 150;
    localparam int HOLD_AFTER     = 150;
    localparam int HOLD_CYCLES    = 120;
    localparam int DRAIN_CYCLES   = 600;
    localparam int TIMEOUT_CYCLES = 3000000;

    // no-op function code, not named in the package
    localparam logic [FUNC_W-1:0] FUNC_NOP = 2'd3;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [FUNC_W-1:0] func;
    logic [WORD_W-1:0] word_value;
    logic              out_valid;
    logic              out_ready;
    logic [CODE_W-1:0] distinct_count;
    logic [CODE_W-1:0] found_code;
    logic              code_valid;
    logic              was_new;

    int fail_count;
    int pending;
    int results_seen;
    int fetch_hits;
    int fetch_misses;
    int new_codes;
    int peak_count;

    int  tx_idle_pct;
    int  rx_stall_pct;
    bit  quiet;
    int  words_sent;
    int  n_feed;
    int  n_fetch;
    int  n_clear;
    int  n_nop;

    distinct_code_bitmap_collector_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .func           (func),
        .word_value     (word_value),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .distinct_count (distinct_count),
        .found_code     (found_code),
        .code_valid     (code_valid),
        .was_new        (was_new)
    );

    dcbc_collector_checker result_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .func           (func),
        .word_value     (word_value),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .distinct_count (distinct_count),
        .found_code     (found_code),
        .code_valid     (code_valid),
        .was_new        (was_new),
        .fail_count     (fail_count),
        .pending        (pending),
        .results_seen   (results_seen),
        .fetch_hits     (fetch_hits),
        .fetch_misses   (fetch_misses),
        .new_codes      (new_codes),
        .peak_count     (peak_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Offer one word from a falling edge, optionally after an idle burst,
    // and return at the falling edge after it is taken
    task automatic offer_word(input logic [FUNC_W-1:0] f, input logic [WORD_W-1:0] w);
        int gap;
        if (!quiet && $urandom_range(0, 99) < tx_idle_pct)
        begin
            gap = $urandom_range(1, 6);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        func       <= f;
        word_value <= w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        words_sent++;
        case (f)
            FUNC_FEED:  n_feed++;
            FUNC_FETCH: n_fetch++;
            FUNC_CLEAR: n_clear++;
            default:    n_nop++;
        endcase
        @(negedge clk);
    endtask

    // Receiver: random stall bursts, plus one long hold-off to back up the block
    initial
    begin : rx_side
        bit held;
        held      = 1'b0;
        out_ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (!held && results_seen >= HOLD_AFTER)
            begin
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else if (!quiet && $urandom_range(0, 99) < rx_stall_pct)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                @(negedge clk);
            end
        end
    end

    initial
    begin : stimulus
        int                ep_len;
        int                span;
        int                roll;
        int                kind;
        logic [WORD_W-1:0] w;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        func         = FUNC_FEED;
        word_value   = '0;
        quiet        = 1'b0;
        tx_idle_pct  = 0;
        rx_stall_pct = 20;
        words_sent   = 0;
        n_feed       = 0;
        n_fetch      = 0;
        n_clear      = 0;
        n_nop        = 0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // fetch on the empty map parks the cursor at the top
        offer_word(FUNC_FETCH, 16'h0000);
        // padding, masked padding, out-of-range codes
        offer_word(FUNC_FEED, 16'h0000);
        offer_word(FUNC_FEED, 16'h8000);
        offer_word(FUNC_FEED, 16'h1000);
        offer_word(FUNC_FEED, 16'hFFFF);
        // top and bottom codes, repeats through the masked bit
        offer_word(FUNC_FEED, 16'h0FFF);
        offer_word(FUNC_FEED, 16'h8FFF);
        offer_word(FUNC_FEED, 16'h0001);
        offer_word(FUNC_FEED, 16'h8001);
        // cursor still parked: stays exhausted until a clear
        offer_word(FUNC_FETCH, 16'hFFFF);
        offer_word(FUNC_CLEAR, 16'h0000);
        offer_word(FUNC_FEED, 16'h0FFF);
        offer_word(FUNC_FEED, 16'h0001);
        offer_word(FUNC_FEED, 16'h0800);
        offer_word(FUNC_FETCH, 16'h0000);
        offer_word(FUNC_FETCH, 16'h0000);
        offer_word(FUNC_FETCH, 16'h0000);
        offer_word(FUNC_FETCH, 16'h0000);
        // a lower code after exhaustion is not returned
        offer_word(FUNC_FEED, 16'h0002);
        offer_word(FUNC_FETCH, 16'h0000);
        offer_word(FUNC_NOP, 16'hFFFF);
        offer_word(FUNC_NOP, 16'h0003);
        offer_word(FUNC_CLEAR, 16'hFFFF);
        offer_word(FUNC_FEED, 16'hAAAA);
        offer_word(FUNC_FEED, 16'h5555);
        offer_word(FUNC_FETCH, 16'h0000);

        // random episodes: a code range, idle and stall mixes, an optional clear, then a burst of mixed words
        while (words_sent < TOTAL_WORDS)
        begin
            quiet = (words_sent >= TOTAL_WORDS - QUIET_WORDS);
            case ($urandom_range(0, 3))
                0:       span = 15;
                1:       span = 63;
                2:       span = 255;
                default: span = CODE_SPACE - 1;
            endcase
            case ($urandom_range(0, 2))
                0:       tx_idle_pct = 0;
                1:       tx_idle_pct = 20;
                default: tx_idle_pct = 50;
            endcase
            case ($urandom_range(0, 2))
                0:       rx_stall_pct = 0;
                1:       rx_stall_pct = 20;
                default: rx_stall_pct = 50;
            endcase
            ep_len = $urandom_range(20, 80);
            if ($urandom_range(0, 9) < 7)
                offer_word(FUNC_CLEAR, WORD_W'($urandom));
            for (int i = 0; i < ep_len && words_sent < TOTAL_WORDS; i++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 55)
                begin
                    kind = $urandom_range(0, 9);
                    if (kind == 0)
                        w = WORD_W'($urandom);
                    else if (kind == 1)
                        w = {1'($urandom), 15'h0000};
                    else if (kind == 2)
                        w = {1'($urandom), 15'($urandom_range(CODE_SPACE, 32767))};
                    else
                        w = {1'($urandom), 3'b000, 12'($urandom_range(1, span))};
                    offer_word(FUNC_FEED, w);
                end
                else if (roll < 88)
                    offer_word(FUNC_FETCH, WORD_W'($urandom));
                else if (roll < 96)
                    offer_word(FUNC_NOP, WORD_W'($urandom));
                else
                    offer_word(FUNC_CLEAR, WORD_W'($urandom));
            end
        end
        in_valid <= 1'b0;

        // drain, then allow for the slowest fetch walk
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Run covered %0d words (%0d feed, %0d fetch, %0d clear, %0d no-op), %0d results compared.",
                 words_sent, n_feed, n_fetch, n_clear, n_nop, results_seen);
        $display("Fetch hits %0d, fetch exhausted %0d, new codes %0d, highest distinct count %0d.",
                 fetch_hits, fetch_misses, new_codes, peak_count);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Watchdog
    initial
    begin
        #(CLK_PERIOD * TIMEOUT_CYCLES);
        $display("Timeout with %0d results outstanding", pending);
        $display("Mismatches found");
        $finish;
    end

endmodule
